// ----- src/dsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the demeaned sample differentiator.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int VALUE_W   = 64;
    localparam int AVG_W     = 49;
    localparam int ERR_W     = 50;
    localparam int DM_W      = 33;
    localparam int FIRST_W   = 50;
    localparam int D2_W      = 51;
    localparam int FRAC_W    = 16;
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = 51;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int WARM_W    = 24;

    localparam logic [15:0] RATE_RST = 16'd100;
    localparam logic [15:0] GAIN_RST = 16'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIFF_ORDER  = 2'd0,
        REG_SAMPLE_RATE = 2'd1,
        REG_AVG_GAIN    = 2'd2,
        REG_WARMUP      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              diff_order;
        logic [15:0]       sample_rate;
        logic [15:0]       avg_gain;
        logic [WARM_W-1:0] warmup_samples;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               ready_res;
        logic [VALUE_W-1:0] value;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MLO,
        S_MHI,
        S_AVG,
        S_DM,
        S_D1,
        S_F1,
        S_D2LO,
        S_D2HI,
        S_SAT,
        S_FIN
    } state_t;

endpackage

// ----- src/dsd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cfg
// Configuration register bank written through the index/data channel.
// ----------------------------------------------------------------------------
module dsd_cfg
    import dsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DIFF_ORDER:  cfg_next.diff_order     = cfg_data[0];
                REG_SAMPLE_RATE: cfg_next.sample_rate    = cfg_data[15:0];
                REG_AVG_GAIN:    cfg_next.avg_gain       = cfg_data[15:0];
                REG_WARMUP:      cfg_next.warmup_samples = cfg_data[WARM_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.diff_order     <= 1'b0;
            cfg_reg.sample_rate    <= RATE_RST;
            cfg_reg.avg_gain       <= GAIN_RST;
            cfg_reg.warmup_samples <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/dsd_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_mult
// Shared signed-by-unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dsd_mult
    import dsd_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic        [MUL_B_W-1:0] mul_b,
    output logic signed [MUL_P_W-1:0] mul_p
);

    logic signed [MUL_B_W:0]   b_ext;
    logic signed [MUL_P_W:0]   prod;
    logic signed [MUL_P_W-1:0] prod_reg;

    assign b_ext = $signed({1'b0, mul_b});
    assign prod  = mul_a * b_ext;
    assign mul_p = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod[MUL_P_W-1:0];
    end

endmodule

// ----- src/dsd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_core
// Sequencer and state: running average, mean removal, differences.
// ----------------------------------------------------------------------------
module dsd_core
    import dsd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                      in_restart,
    output res_t                      res,
    input  logic                      res_ready,
    output logic signed [MUL_A_W-1:0] mul_a,
    output logic        [MUL_B_W-1:0] mul_b,
    input  logic signed [MUL_P_W-1:0] mul_p
);

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    state_t                     state_reg, state_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic        [FRAC_W-1:0]   frac_reg, frac_next;
    logic        [31:0]         lo_reg, lo_next;
    logic signed [AVG_W-1:0]    avg_reg, avg_next;
    logic signed [DM_W-1:0]     dm_reg, dm_next;
    logic signed [DM_W-1:0]     prev_dm_reg, prev_dm_next;
    logic signed [FIRST_W-1:0]  prev_first_reg, prev_first_next;
    logic signed [D2_W-1:0]     d2_reg, d2_next;
    logic        [WARM_W-1:0]   warm_reg, warm_next;
    logic        [VALUE_W-1:0]  value_reg, value_next;
    logic                       flag_reg, flag_next;

    logic signed [AVG_W+1:0]    avg_sum;
    logic signed [DM_W:0]       dm_full;
    logic signed [DM_W:0]       d1_in;
    logic signed [FIRST_W-1:0]  first;
    logic signed [67:0]         sat_sum;

    assign in_ready = (state_reg == S_IDLE);

    assign avg_sum = {{2{avg_reg[AVG_W-1]}}, avg_reg}
                   + mul_p
                   + $signed({35'd0, frac_reg});
    assign dm_full = {x_reg[SAMPLE_W-1], x_reg[SAMPLE_W-1], x_reg}
                   - {avg_reg[AVG_W-1], avg_reg[AVG_W-1:FRAC_W]};
    assign d1_in   = {dm_reg[DM_W-1], dm_reg} - {prev_dm_reg[DM_W-1], prev_dm_reg};
    assign first   = mul_p[FIRST_W-1:0];
    assign sat_sum = $signed({mul_p[MUL_P_W-1], mul_p, 16'h0000})
                   + $signed({36'd0, lo_reg});

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        err_next        = err_reg;
        frac_next       = frac_reg;
        lo_next         = lo_reg;
        avg_next        = avg_reg;
        dm_next         = dm_reg;
        prev_dm_next    = prev_dm_reg;
        prev_first_next = prev_first_reg;
        d2_next         = d2_reg;
        warm_next       = warm_reg;
        value_next      = value_reg;
        flag_next       = flag_reg;
        mul_a           = '0;
        mul_b           = cfg.sample_rate;
        res.valid       = 1'b0;
        res.ready_res   = flag_reg;
        res.value       = value_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    x_next = in_sample;
                    if (in_restart) begin
                        avg_next        = '0;
                        prev_dm_next    = '0;
                        prev_first_next = '0;
                        warm_next       = '0;
                    end
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next = {x_reg[SAMPLE_W-1], x_reg[SAMPLE_W-1], x_reg, 16'h0000}
                         - {avg_reg[AVG_W-1], avg_reg};
                state_next = S_MLO;
            end
            S_MLO: begin
                mul_a      = $signed({19'd0, err_reg[FRAC_W-1:0]});
                mul_b      = cfg.avg_gain;
                state_next = S_MHI;
            end
            S_MHI: begin
                mul_a      = {err_reg[ERR_W-1], err_reg[ERR_W-1:FRAC_W]};
                mul_b      = cfg.avg_gain;
                frac_next  = mul_p[31:16];
                state_next = S_AVG;
            end
            S_AVG: begin
                avg_next   = avg_sum[AVG_W-1:0];
                state_next = S_DM;
            end
            S_DM: begin
                dm_next = dm_full[DM_W-1:0];
                if (warm_reg < cfg.warmup_samples) begin
                    warm_next  = warm_reg + 1'b1;
                    value_next = {{(VALUE_W-DM_W-1){dm_full[DM_W]}}, dm_full};
                    flag_next  = 1'b0;
                    state_next = S_FIN;
                end else begin
                    state_next = S_D1;
                end
            end
            S_D1: begin
                mul_a      = {d1_in[DM_W], d1_in};
                state_next = S_F1;
            end
            S_F1: begin
                prev_dm_next    = dm_reg;
                prev_first_next = first;
                flag_next       = 1'b1;
                if (!cfg.diff_order) begin
                    value_next = {{(VALUE_W-FIRST_W){first[FIRST_W-1]}}, first};
                    state_next = S_FIN;
                end else begin
                    d2_next = {first[FIRST_W-1], first}
                            - {prev_first_reg[FIRST_W-1], prev_first_reg};
                    state_next = S_D2LO;
                end
            end
            S_D2LO: begin
                mul_a      = $signed({19'd0, d2_reg[FRAC_W-1:0]});
                state_next = S_D2HI;
            end
            S_D2HI: begin
                mul_a      = d2_reg[D2_W-1:FRAC_W];
                lo_next    = mul_p[31:0];
                state_next = S_SAT;
            end
            S_SAT: begin
                if (sat_sum[67:63] != {5{sat_sum[63]}}) begin
                    value_next = sat_sum[67] ? VAL_MIN : VAL_MAX;
                end else begin
                    value_next = sat_sum[VALUE_W-1:0];
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            avg_reg        <= '0;
            prev_dm_reg    <= '0;
            prev_first_reg <= '0;
            warm_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            avg_reg        <= avg_next;
            prev_dm_reg    <= prev_dm_next;
            prev_first_reg <= prev_first_next;
            warm_reg       <= warm_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        err_reg   <= err_next;
        frac_reg  <= frac_next;
        lo_reg    <= lo_next;
        dm_reg    <= dm_next;
        d2_reg    <= d2_next;
        value_reg <= value_next;
        flag_reg  <= flag_next;
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while sequencer busy");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_restart) |=> (warm_reg == '0 && avg_reg == '0))
        else $error("restart did not clear state");

    a_warm_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DM && warm_reg < cfg.warmup_samples) |=> !flag_reg)
        else $error("warm-up result flagged as derivative");

    a_res_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (state_reg == S_FIN))
        else $error("result raised outside final state");

endmodule

// ----- src/demeaned_sample_differentiator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demeaned_sample_differentiator
// Running-average removal followed by a scaled first or second difference.
// ----------------------------------------------------------------------------
// Input words arrive on s_* (sample in tdata, restart flag in tuser); one
// result word per input leaves on m_* (value in tdata, derivative flag in
// tuser). Registers are to be written over cfg_* by the user only while
// the block is idle; the block itself does not enforce this. One shared
// 35x16 multiplier serves the average update and both differences under a
// small sequencer; the block takes one word at a time. An accepted word
// passes the error step, the low and high average multiplies, the average
// update and mean removal; outside warm-up it goes on to the first
// difference and, for the second order, the low and high scaling multiplies and saturation.
// The result goes into an output register; while the receiver stalls with
// a word pending, the sequencer holds its last step and s_tready stays low.
// Synchronous reset clears the average, history, warm-up count and output
// valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module demeaned_sample_differentiator
    import dsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] sample_in
    input  logic                 s_tuser,   // [0] restart
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [63:0] value_out
    output logic                 m_tuser,   // [0] ready_res
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t                      cfg;
    res_t                      res;
    logic                      res_ready;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]        out_data_reg, out_data_next;
    logic                      out_user_reg, out_user_next;

    dsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsd_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    dsd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  ($signed(s_tdata)),
        .in_restart (s_tuser),
        .res        (res),
        .res_ready  (res_ready),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_p      (mul_p)
    );

    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res.valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res.value;
            out_user_next  = res.ready_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

// ----- tb/sv/demeaned_sample_differentiator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demeaned_sample_differentiator_tb
// Self-checking bench for the running-average removal and scaled difference.
// ----------------------------------------------------------------------------
// A directed table first covers the register defaults, warm-up and its early
// end, restart, both difference orders, saturation at both rails, zero rate
// and zero gain. Random segments follow. Each one loads new register values
// and runs with its own mix of sender gaps and receiver stalls. A bit-exact
// fixed-point model in the bench predicts each output word. Output words are
// checked in order against those predictions.
// ----------------------------------------------------------------------------
module demeaned_sample_differentiator_tb
    import dsd_pkg::*;
();

    typedef struct packed {
        logic        deriv;
        logic [63:0] value;
    } outcome_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        cfg_idx_t                idx;
        logic [CFG_DAT_W-1:0]    data;
        logic signed [31:0]      smp;
        logic                    rst;
        logic                    known;
        outcome_t                want;
    } row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // [31:0] sample_in
    logic                 s_tuser   = 1'b0; // [0] restart
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [63:0] value_out
    logic                 m_tuser;          // [0] ready_res
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = REG_DIFF_ORDER;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // model registers and state
    cfg_t                      model_cfg = '{diff_order: 1'b0, sample_rate: RATE_RST,
                                             avg_gain: GAIN_RST, warmup_samples: '0};
    logic signed [AVG_W-1:0]   avg_q16   = '0;
    logic signed [DM_W-1:0]    last_dm   = '0;
    logic signed [63:0]        last_slope = '0;
    logic [WARM_W-1:0]         warm_cnt  = '0;

    outcome_t due_results[$];
    row_t     stim_rows[$];
    int       mismatch_count = 0;
    int       gap_pct   = 0;
    int       stall_pct = 0;

    demeaned_sample_differentiator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // a * r clipped to the signed 64-bit range
    function automatic logic signed [63:0] scale_sat(input logic signed [63:0] a,
                                                     input logic [15:0] r);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({112'd0, r});
        if (p[127:63] != {65{p[127]}})
            return p[127] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
        return p[63:0];
    endfunction

    function automatic outcome_t predict_derivative(input logic signed [31:0] smp,
                                                    input logic rst);
        longint   xs, gain, rate, acc, err, hi, lo, dm, first;
        outcome_t res;
        xs   = smp;
        gain = model_cfg.avg_gain;
        rate = model_cfg.sample_rate;
        if (rst) begin
            avg_q16    = '0;
            last_dm    = '0;
            last_slope = '0;
            warm_cnt   = '0;
        end
        acc = avg_q16;
        err = (xs <<< 16) - acc;
        hi  = err >>> 16;
        lo  = err - (hi <<< 16);
        acc = acc + gain * hi + ((gain * lo) >>> 16);
        avg_q16 = acc[AVG_W-1:0];
        dm  = xs - (acc >>> 16);
        if (warm_cnt < model_cfg.warmup_samples) begin
            warm_cnt  = warm_cnt + 1'b1;
            res.value = dm;
            res.deriv = 1'b0;
        end else begin
            first = scale_sat(dm - longint'(last_dm), rate[15:0]);
            res.value = model_cfg.diff_order ? scale_sat(first - last_slope, rate[15:0])
                                             : first;
            last_dm    = dm[DM_W-1:0];
            last_slope = first;
            res.deriv  = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        outcome_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 64'd0);
            end else begin
                exp_res = due_results.pop_front();
                if (m_tdata !== exp_res.value)
                    report_mismatch("value_out", m_tdata, exp_res.value);
                if (m_tuser !== exp_res.deriv)
                    report_mismatch("ready_res", {63'd0, m_tuser}, {63'd0, exp_res.deriv});
            end
        end
    end

    // enters and leaves on a rising-edge step
    task automatic send_word(input logic signed [31:0] smp, input logic rst,
                             input logic known, input outcome_t want);
        outcome_t res;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= rst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = predict_derivative(smp, rst);
        due_results.push_back(known ? want : res);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        unique case (idx)
            REG_DIFF_ORDER:  model_cfg.diff_order     = val[0];
            REG_SAMPLE_RATE: model_cfg.sample_rate    = val[15:0];
            REG_AVG_GAIN:    model_cfg.avg_gain       = val[15:0];
            REG_WARMUP:      model_cfg.warmup_samples = val[WARM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // drain all pending words, then let the sequencer go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        row_t r;
        r = '{kind: ROW_REG, idx: idx, data: val, smp: '0, rst: 1'b0, known: 1'b0,
              want: '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_word(input logic signed [31:0] smp, input logic rst,
                            input logic known, input logic signed [63:0] val,
                            input logic deriv);
        row_t r;
        r = '{kind: ROW_WORD, idx: REG_DIFF_ORDER, data: '0, smp: smp, rst: rst,
              known: known, want: '{deriv: deriv, value: val}};
        stim_rows.push_back(r);
    endtask

    function automatic logic signed [31:0] pick_sample();
        unique case ($urandom_range(9))
            0: begin
                unique case ($urandom_range(3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(2000)) - 32'sd1000;
            4, 5:    return $urandom;
            default: return $signed($urandom_range(32'h001FFFFF)) - 32'sh00100000;
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        unique case ($urandom_range(7))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return ($urandom_range(15) == 0) ? 16'd0 : 16'd100;
            3: return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_warmup();
        unique case ($urandom_range(9))
            0:          return 24'hFFFFFF;
            1, 2, 3, 4: return 24'($urandom_range(1, 8));
            default:    return '0;
        endcase
    endfunction

    initial begin
        logic                    rst;
        logic [CFG_DAT_W-1:0]    val;

        // defaults after reset, then warm-up with zero gain so dm equals the sample
        add_word(32'sd0, 1'b0, 1'b1, 64'sd0, 1'b1);
        add_reg(REG_AVG_GAIN, 24'd0);
        add_reg(REG_WARMUP, 24'd4);
        add_word(32'sd0, 1'b1, 1'b1, 64'sd0, 1'b0);
        add_word(32'sh7FFFFFFF, 1'b0, 1'b1, 64'sd2147483647, 1'b0);
        add_word(32'sh80000000, 1'b0, 1'b1, -64'sd2147483648, 1'b0);
        add_word(32'sd12345, 1'b0, 1'b1, 64'sd12345, 1'b0);
        add_word(32'sd12345, 1'b0, 1'b1, 64'sd1234500, 1'b1);
        add_word(32'sd12345, 1'b0, 1'b1, 64'sd0, 1'b1);
        add_word(32'sh80000000, 1'b0, 1'b1, -64'sd214749599300, 1'b1);
        add_word(32'sh7FFFFFFF, 1'b0, 1'b1, 64'sd429496729500, 1'b1);
        add_word(32'sd5, 1'b1, 1'b1, 64'sd5, 1'b0);
        add_reg(REG_WARMUP, 24'hFFFFFF);
        add_word(-32'sd7, 1'b0, 1'b1, -64'sd7, 1'b0);
        // lowering the warm-up length ends it at once
        add_reg(REG_WARMUP, 24'd0);
        add_word(32'sd3, 1'b0, 1'b1, 64'sd300, 1'b1);
        // second difference at full rate, clipping on both rails
        add_reg(REG_DIFF_ORDER, 24'd1);
        add_reg(REG_SAMPLE_RATE, 24'hFFFF);
        add_word(32'sh80000000, 1'b1, 1'b0, '0, 1'b0);
        add_word(32'sh7FFFFFFF, 1'b0, 1'b1, 64'sh7FFFFFFFFFFFFFFF, 1'b1);
        add_word(32'sh80000000, 1'b0, 1'b1, 64'sh8000000000000000, 1'b1);
        add_word(32'sh80000000, 1'b0, 1'b1, 64'sh7FFFFFFFFFFFFFFF, 1'b1);
        add_reg(REG_SAMPLE_RATE, 24'd0);
        add_word(32'sd777, 1'b0, 1'b1, 64'sd0, 1'b1);
        add_word(-32'sd1, 1'b0, 1'b1, 64'sd0, 1'b1);
        // average tracking at the gain extremes
        add_reg(REG_DIFF_ORDER, 24'd0);
        add_reg(REG_SAMPLE_RATE, 24'd1);
        add_reg(REG_AVG_GAIN, 24'hFFFF);
        add_word(32'sd1000, 1'b1, 1'b0, '0, 1'b0);
        add_word(-32'sd1000, 1'b0, 1'b0, '0, 1'b0);
        add_word(32'sd0, 1'b0, 1'b0, '0, 1'b0);
        add_reg(REG_AVG_GAIN, 24'd1);
        add_word(32'sh7FFFFFFF, 1'b1, 1'b0, '0, 1'b0);
        add_word(32'sh80000000, 1'b0, 1'b0, '0, 1'b0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_word(stim_rows[i].smp, stim_rows[i].rst, stim_rows[i].known,
                          stim_rows[i].want);
            end
        end

        for (int seg = 0; seg < 8; seg++) begin
            settle();
            unique case (seg % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 54; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 54; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            val = 24'($urandom_range(1));
            write_reg(REG_DIFF_ORDER, val);
            write_reg(REG_SAMPLE_RATE, {8'd0, pick_scale()});
            write_reg(REG_AVG_GAIN, {8'd0, pick_scale()});
            write_reg(REG_WARMUP, pick_warmup());
            for (int n = 0; n < 75; n++) begin
                rst = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
                send_word(pick_sample(), rst, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
